FILE: hdl/clpr_pkg.sv
// Shared constants for the CLOCK/LRU page replacement queue.
package clpr_pkg;

   localparam int OPCODE_W = 2;
   localparam int KIND_W   = 2;
   localparam int CSR_W    = 6;

   localparam logic [OPCODE_W-1:0] OP_MAP    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ACCESS = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_EVICT  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_REVOKED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EVICTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [KIND_W-1:0]   kind_type;

endpackage

FILE: hdl/clpr_req_if.sv
// Request channel interface: opcode and page number beats.
interface clpr_req_if
   import clpr_pkg::*;
#(
   parameter int PAGE_BITS = 20
);
   logic                 valid;
   logic                 ready;
   opcode_type           opcode;
   logic [PAGE_BITS-1:0] page_number;

   modport source (output valid, output opcode, output page_number, input ready);
   modport sink   (input valid, input opcode, input page_number, output ready);
endinterface

FILE: hdl/clpr_rsp_if.sv
// Response channel interface: revoked, evicted and error beats.
interface clpr_rsp_if
   import clpr_pkg::*;
#(
   parameter int PAGE_BITS = 20
);
   logic                 valid;
   logic                 ready;
   kind_type             result_kind;
   logic [PAGE_BITS-1:0] result_page;
   logic                 last_of_run;

   modport source (output valid, output result_kind, output result_page,
                   output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input result_page,
                   input last_of_run, output ready);
endinterface

FILE: hdl/clpr_ram.sv
// Generic single write, single registered read RAM.
module clpr_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/clock_lru_page_replacement.sv
// CLOCK/LRU aging queue for page replacement, top level.
//
// req_bus takes one op per beat: map appends a page at the tail, access marks
// every resident copy of a page, tick walks the queue once and moves marked
// pages to the tail (reporting each as revoked), evict pops the head.
// rsp_bus carries revoked/evicted/error beats; last_of_run flags the final
// beat of an op. csr_write_enable/csr_write_data set the resident limit
// (0 acts as 1, anything above RESIDENT_SLOTS as RESIDENT_SLOTS).
// A successful map completes in the idle state; evict and error results are
// loaded into the output register. A tick with nothing marked returns to
// idle without a walk. The queue store walk reads one entry a cycle through
// the RAM's single read port, though rsp_bus can hold a tick walk; the tick
// second pass copies the moved pages back one a cycle from a scratch RAM.
// req_bus.ready is high only when the sequencer is idle.
// A stall on rsp_bus holds the walk at the next marked entry; the output
// register frees as soon as its beat is taken.
// Reset empties the queue, clears all marks and sets the limit to
// RESIDENT_SLOTS; it takes effect on the next clock edge.
module clock_lru_page_replacement
   import clpr_pkg::*;
#(
   parameter int RESIDENT_SLOTS = 32,
   parameter int PAGE_BITS      = 20
) (
   input  logic              clock,
   input  logic              reset,
   clpr_req_if.sink          req_bus,
   clpr_rsp_if.source        rsp_bus,
   input  logic              csr_write_enable,
   input  logic [CSR_W-1:0]  csr_write_data
);
   localparam int SLOT_W = $clog2(RESIDENT_SLOTS);
   localparam int CNT_W  = $clog2(RESIDENT_SLOTS + 1);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] ST_ERR    = 3'd1;
   localparam logic [ST_W-1:0] ST_EVICT  = 3'd2;
   localparam logic [ST_W-1:0] ST_ACCESS = 3'd3;
   localparam logic [ST_W-1:0] ST_TICK   = 3'd4;
   localparam logic [ST_W-1:0] ST_COPY   = 3'd5;

   function automatic logic [SLOT_W-1:0] slot_f(input logic [SLOT_W-1:0] head,
                                                input logic [CNT_W-1:0]  pos);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
      if (sum >= (CNT_W+1)'(RESIDENT_SLOTS)) begin
         sum = sum - (CNT_W+1)'(RESIDENT_SLOTS);
      end
      return sum[SLOT_W-1:0];
   endfunction

   logic [ST_W-1:0]           state_ff, state_in;
   logic [SLOT_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          marked_cnt_ff, marked_cnt_in;
   logic [CNT_W-1:0]          limit_ff, limit_in;
   logic [PAGE_BITS-1:0]      page_ff, page_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          nk_ff, nk_in;
   logic [CNT_W-1:0]          nm_ff, nm_in;
   logic [CNT_W-1:0]          wi_ff, wi_in;
   logic                      vld_ff, vld_in;
   logic [RESIDENT_SLOTS-1:0] marks_ff, marks_in;

   logic                    rsp_valid_ff;
   kind_type                rsp_kind_ff;
   logic [PAGE_BITS-1:0]    rsp_page_ff;
   logic                    rsp_last_ff;

   logic                    rsp_load;
   kind_type                load_kind;
   logic [PAGE_BITS-1:0]    load_page;
   logic                    load_last;

   logic                    q_we;
   logic [SLOT_W-1:0]       q_wa;
   logic [PAGE_BITS-1:0]    q_wd;
   logic [SLOT_W-1:0]       q_ra;
   logic [PAGE_BITS-1:0]    q_rd;
   logic                    s_we;
   logic [PAGE_BITS-1:0]    s_rd;

   logic                    accept;
   logic                    can_emit;
   logic [SLOT_W-1:0]       cur_slot;
   logic [CNT_W-1:0]        idx_nx;
   logic                    last_idx;
   logic                    cur_mark;
   logic                    consume;

   clpr_ram #(.WIDTH(PAGE_BITS), .DEPTH(RESIDENT_SLOTS)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_wa),
      .wr_data (q_wd),
      .rd_addr (q_ra),
      .rd_data (q_rd)
   );

   clpr_ram #(.WIDTH(PAGE_BITS), .DEPTH(RESIDENT_SLOTS)) u_moved_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (nm_ff[SLOT_W-1:0]),
      .wr_data (q_rd),
      .rd_addr (idx_ff[SLOT_W-1:0]),
      .rd_data (s_rd)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign can_emit      = !rsp_valid_ff || rsp_bus.ready;
   assign cur_slot      = slot_f(head_ff, idx_ff);
   assign idx_nx        = idx_ff + CNT_W'(1);
   assign last_idx      = (idx_nx == count_ff);
   assign cur_mark      = marks_ff[cur_slot];
   assign consume       = !cur_mark || can_emit;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      marked_cnt_in = marked_cnt_ff;
      limit_in      = limit_ff;
      page_in       = page_ff;
      idx_in        = idx_ff;
      nk_in         = nk_ff;
      nm_in         = nm_ff;
      wi_in         = wi_ff;
      vld_in        = vld_ff;
      marks_in      = marks_ff;
      rsp_load      = 1'b0;
      load_kind     = KIND_ERROR;
      load_page     = '0;
      load_last     = 1'b1;
      q_we          = 1'b0;
      q_wa          = slot_f(head_ff, nk_ff);
      q_wd          = q_rd;
      q_ra          = cur_slot;
      s_we          = 1'b0;

      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            limit_in = CNT_W'(1);
         end else if (int'(csr_write_data) > RESIDENT_SLOTS) begin
            limit_in = CNT_W'(RESIDENT_SLOTS);
         end else begin
            limit_in = CNT_W'(csr_write_data);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            q_ra = head_ff;
            if (accept) begin
               page_in = req_bus.page_number;
               idx_in  = '0;
               nk_in   = '0;
               nm_in   = '0;
               wi_in   = '0;
               vld_in  = 1'b0;
               case (req_bus.opcode)
                  OP_MAP: begin
                     if (count_ff >= limit_ff) begin
                        state_in = ST_ERR;
                     end else begin
                        q_we     = 1'b1;
                        q_wa     = slot_f(head_ff, count_ff);
                        q_wd     = req_bus.page_number;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_ACCESS: begin
                     if (count_ff != '0) begin
                        state_in = ST_ACCESS;
                        vld_in   = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     if (marked_cnt_ff != '0) begin
                        state_in = ST_TICK;
                        vld_in   = 1'b1;
                     end
                  end
                  default: begin
                     state_in = (count_ff == '0) ? ST_ERR : ST_EVICT;
                  end
               endcase
            end
         end

         ST_ERR: begin
            if (can_emit) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_EVICT: begin
            q_ra = head_ff;
            if (can_emit) begin
               rsp_load  = 1'b1;
               load_kind = KIND_EVICTED;
               load_page = q_rd;
               if (marks_ff[head_ff]) begin
                  marks_in[head_ff] = 1'b0;
                  marked_cnt_in     = marked_cnt_ff - CNT_W'(1);
               end
               head_in  = slot_f(head_ff, CNT_W'(1));
               count_in = count_ff - CNT_W'(1);
               state_in = ST_IDLE;
            end
         end

         ST_ACCESS: begin
            if (vld_ff) begin
               if (q_rd == page_ff && !cur_mark) begin
                  marks_in[cur_slot] = 1'b1;
                  marked_cnt_in      = marked_cnt_ff + CNT_W'(1);
               end
               if (last_idx) begin
                  vld_in   = 1'b0;
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_nx;
                  q_ra   = slot_f(head_ff, idx_nx);
               end
            end
         end

         ST_TICK: begin
            if (vld_ff && consume) begin
               if (cur_mark) begin
                  s_we      = 1'b1;
                  rsp_load  = 1'b1;
                  load_kind = KIND_REVOKED;
                  load_page = q_rd;
                  load_last = ((nm_ff + CNT_W'(1)) == marked_cnt_ff);
                  nm_in     = nm_ff + CNT_W'(1);
               end else begin
                  q_we  = 1'b1;
                  nk_in = nk_ff + CNT_W'(1);
               end
               if (last_idx) begin
                  vld_in   = 1'b0;
                  idx_in   = '0;
                  wi_in    = '0;
                  state_in = ST_COPY;
               end else begin
                  idx_in = idx_nx;
                  q_ra   = slot_f(head_ff, idx_nx);
               end
            end
         end

         ST_COPY: begin
            if (idx_ff != nm_ff) begin
               idx_in = idx_nx;
               vld_in = 1'b1;
            end else begin
               vld_in = 1'b0;
            end
            if (vld_ff) begin
               q_we  = 1'b1;
               q_wa  = slot_f(head_ff, CNT_W'(nk_ff + wi_ff));
               q_wd  = s_rd;
               wi_in = wi_ff + CNT_W'(1);
               if ((wi_ff + CNT_W'(1)) == nm_ff) begin
                  marks_in      = '0;
                  marked_cnt_in = '0;
                  idx_in        = '0;
                  vld_in        = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         marked_cnt_ff <= '0;
         limit_ff      <= CNT_W'(RESIDENT_SLOTS);
         idx_ff        <= '0;
         nk_ff         <= '0;
         nm_ff         <= '0;
         wi_ff         <= '0;
         vld_ff        <= 1'b0;
         marks_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         marked_cnt_ff <= marked_cnt_in;
         limit_ff      <= limit_in;
         idx_ff        <= idx_in;
         nk_ff         <= nk_in;
         nm_ff         <= nm_in;
         wi_ff         <= wi_in;
         vld_ff        <= vld_in;
         marks_ff      <= marks_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      if (rsp_load) begin
         rsp_kind_ff <= load_kind;
         rsp_page_ff <= load_page;
         rsp_last_ff <= load_last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_kind = rsp_kind_ff;
   assign rsp_bus.result_page = rsp_page_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

endmodule

FILE: verif/clpr_scoreboard_pkg.sv
// Page queue predictor and result beat checker for the CLOCK/LRU testbench.
`timescale 1ns / 100ps
package clpr_scoreboard_pkg;
   import clpr_pkg::*;

   localparam int RESIDENT_SLOTS = 32;
   localparam int PAGE_BITS      = 20;

   typedef logic [PAGE_BITS-1:0] page_type;

   typedef struct {
      page_type page;
      bit       marked;
   } resident_entry;

   typedef struct {
      kind_type kind;
      page_type page;
      bit       last;
   } page_outcome;

   class page_queue_scoreboard;
      resident_entry    resident[$];
      page_outcome      outcomes_due[$];
      logic [CSR_W-1:0] limit_reg;
      int unsigned      mismatches;
      int unsigned      ops_applied;
      int unsigned      kind_seen[3];
      int unsigned      widest_tick;

      function new();
         limit_reg = CSR_W'(RESIDENT_SLOTS);
      endfunction

      function int unsigned resident_cap();
         if (limit_reg == 0) return 1;
         if (limit_reg > RESIDENT_SLOTS) return RESIDENT_SLOTS;
         return 32'(limit_reg);
      endfunction

      function void write_limit(logic [CSR_W-1:0] value);
         limit_reg = value;
      endfunction

      function int unsigned depth();
         return resident.size();
      endfunction

      function int unsigned pending();
         return outcomes_due.size();
      endfunction

      function void push_outcome(kind_type kind, page_type page);
         page_outcome beat;
         beat.kind = kind;
         beat.page = page;
         beat.last = 1'b0;
         outcomes_due.push_back(beat);
      endfunction

      function void note_request(opcode_type op, page_type page);
         int unsigned   queued;
         resident_entry entry;
         resident_entry kept[$];
         resident_entry moved[$];
         page_outcome   tail;
         queued = outcomes_due.size();
         case (op)
            OP_MAP: begin
               if (resident.size() >= resident_cap()) begin
                  push_outcome(KIND_ERROR, '0);
               end else begin
                  entry.page   = page;
                  entry.marked = 1'b0;
                  resident.push_back(entry);
               end
            end
            OP_ACCESS: begin
               foreach (resident[i]) begin
                  if (resident[i].page == page) begin
                     resident[i].marked = 1'b1;
                  end
               end
            end
            OP_TICK: begin
               foreach (resident[i]) begin
                  entry        = resident[i];
                  entry.marked = 1'b0;
                  if (resident[i].marked) begin
                     push_outcome(KIND_REVOKED, entry.page);
                     moved.push_back(entry);
                  end else begin
                     kept.push_back(entry);
                  end
               end
               resident = {kept, moved};
               if (moved.size() > widest_tick) widest_tick = moved.size();
            end
            default: begin
               if (resident.size() == 0) begin
                  push_outcome(KIND_ERROR, '0);
               end else begin
                  entry = resident.pop_front();
                  push_outcome(KIND_EVICTED, entry.page);
               end
            end
         endcase
         ops_applied++;
         if (outcomes_due.size() > queued) begin
            tail      = outcomes_due.pop_back();
            tail.last = 1'b1;
            outcomes_due.push_back(tail);
         end
      endfunction

      function void check_result(kind_type kind, page_type page, logic last);
         page_outcome due;
         if (outcomes_due.size() == 0) begin
            $display("[%0t] unexpected result beat: kind %0d page %05h last %0b",
                     $time, kind, page, last);
            mismatches++;
            return;
         end
         due = outcomes_due.pop_front();
         kind_seen[due.kind]++;
         if (kind !== due.kind) begin
            $display("[%0t] result_kind expected %0d actual %0d", $time, due.kind, kind);
            mismatches++;
         end
         if (page !== due.page) begin
            $display("[%0t] result_page expected %05h actual %05h", $time, due.page, page);
            mismatches++;
         end
         if (last !== due.last) begin
            $display("[%0t] last_of_run expected %0b actual %0b", $time, due.last, last);
            mismatches++;
         end
      endfunction
   endclass

endpackage

FILE: verif/tb_clock_lru_page_replacement.sv
// Top-level testbench for the CLOCK/LRU page replacement queue.
`timescale 1ns / 100ps
module tb_clock_lru_page_replacement;
   import clpr_pkg::*;
   import clpr_scoreboard_pkg::*;

   localparam int ITEM_TARGET   = 450;
   localparam int SETTLE_CYCLES = RESIDENT_SLOTS + 8;
   localparam int STALL_LIMIT   = 4000;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_ITEMS   = 70;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [CSR_W-1:0] csr_write_data;

   page_type    page_pool[8];
   bit          calm;
   int unsigned hold_off_request;
   int unsigned limits_applied;

   page_queue_scoreboard sb = new;

   clpr_req_if #(.PAGE_BITS(PAGE_BITS)) req_bus ();
   clpr_rsp_if #(.PAGE_BITS(PAGE_BITS)) rsp_bus ();

   clock_lru_page_replacement #(
      .RESIDENT_SLOTS(RESIDENT_SLOTS),
      .PAGE_BITS     (PAGE_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.opcode, req_bus.page_number);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.result_kind, rsp_bus.result_page, rsp_bus.last_of_run);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[%0t] no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int unsigned idle_span();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : rsp_sink
      int unsigned span;
      forever begin
         if (hold_off_request > 0) begin
            span             = hold_off_request;
            hold_off_request = 0;
            rsp_bus.ready <= 1'b0;
         end else if (calm) begin
            span = 1;
            rsp_bus.ready <= 1'b1;
         end else begin
            span = idle_span() + 1;
            rsp_bus.ready <= ($urandom_range(0, 99) < 70);
         end
         repeat (span) @(posedge clock);
      end
   end

   function automatic page_type pick_page();
      if ($urandom_range(0, 3) != 0) return page_pool[$urandom_range(0, 7)];
      return page_type'($urandom_range(0, (1 << PAGE_BITS) - 1));
   endfunction

   function automatic opcode_type pick_op();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return OP_MAP;
      if (roll < 65) return OP_ACCESS;
      if (roll < 80) return OP_TICK;
      return OP_EVICT;
   endfunction

   task automatic send_item(opcode_type op, page_type page);
      int unsigned gap;
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.page_number <= page;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = idle_span();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic idle_request();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_quiet();
      idle_request();
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(logic [CSR_W-1:0] value);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      sb.write_limit(value);
      csr_write_enable <= 1'b0;
      limits_applied++;
   endtask

   task automatic mixed_run(int unsigned beats);
      repeat (beats) send_item(pick_op(), pick_page());
   endtask

   // full_marks: pool pages only, then touch the whole pool so every pool-page entry ages out
   task automatic fill_and_age(bit full_marks);
      int room;
      idle_request();
      room = int'(sb.resident_cap()) - int'(sb.depth());
      if (room < 0) room = 0;
      repeat (room + 1)
         send_item(OP_MAP, full_marks ? page_pool[$urandom_range(0, 7)] : pick_page());
      if (full_marks) begin
         foreach (page_pool[i]) send_item(OP_ACCESS, page_pool[i]);
      end else begin
         repeat ($urandom_range(1, 4)) send_item(OP_ACCESS, pick_page());
      end
      send_item(OP_TICK, pick_page());
      if ($urandom_range(0, 1) != 0) send_item(OP_TICK, pick_page());
   endtask

   task automatic drain_queue();
      idle_request();
      repeat (sb.depth() + 1) send_item(OP_EVICT, pick_page());
   endtask

   task automatic back_pressure_run();
      wait_quiet();
      hold_off_request = LONG_HOLD;
      drain_queue();
      fill_and_age(1'b1);
      mixed_run(10);
   endtask

   initial begin : stimulus
      logic [CSR_W-1:0] limit_plan[6];
      int unsigned      phase;
      int unsigned      next_phase_at;
      int unsigned      roll;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = OP_MAP;
      req_bus.page_number = '0;
      calm                = 1'b0;
      hold_off_request    = 0;
      limits_applied      = 0;
      page_pool[0]        = '0;
      page_pool[1]        = '1;
      for (int i = 2; i < 8; i++)
         page_pool[i] = page_type'($urandom_range(0, (1 << PAGE_BITS) - 1));
      limit_plan = '{6'd1, 6'd0, 6'd63, 6'd33, 6'd7, 6'd32};
      limit_plan[4] = CSR_W'($urandom_range(2, RESIDENT_SLOTS - 1));
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_limit(CSR_W'(RESIDENT_SLOTS));
      send_item(OP_EVICT, '0);
      send_item(OP_TICK, '1);
      send_item(OP_MAP, '0);
      send_item(OP_MAP, '1);
      send_item(OP_MAP, '0);
      send_item(OP_MAP, 20'hA5A5A);
      send_item(OP_ACCESS, '0);
      send_item(OP_ACCESS, 20'h12345);
      send_item(OP_TICK, '0);
      send_item(OP_TICK, '0);
      send_item(OP_ACCESS, '1);
      send_item(OP_EVICT, '0);
      // limit dropped below the resident count
      set_limit(6'd2);
      send_item(OP_MAP, 20'h55555);
      send_item(OP_EVICT, '0);
      send_item(OP_EVICT, '0);
      send_item(OP_MAP, 20'h55555);
      send_item(OP_MAP, 20'h2AAAA);
      set_limit(6'd0);
      send_item(OP_MAP, 20'h00001);
      send_item(OP_EVICT, '0);
      send_item(OP_EVICT, '0);
      send_item(OP_MAP, 20'h00001);
      send_item(OP_MAP, 20'h00002);
      set_limit(6'd63);
      send_item(OP_ACCESS, 20'h00001);
      send_item(OP_TICK, '0);
      send_item(OP_EVICT, '0);
      send_item(OP_EVICT, '0);

      back_pressure_run();

      phase         = 0;
      next_phase_at = sb.ops_applied + PHASE_ITEMS;
      idle_request();
      while (sb.ops_applied < ITEM_TARGET) begin
         if (sb.ops_applied >= next_phase_at) begin
            set_limit(limit_plan[phase % 6]);
            phase++;
            next_phase_at = sb.ops_applied + PHASE_ITEMS;
         end
         roll = $urandom_range(0, 9);
         if (roll < 5) begin
            mixed_run($urandom_range(10, 30));
         end else if (roll < 7) begin
            fill_and_age($urandom_range(0, 2) == 0);
         end else if (roll < 8) begin
            drain_queue();
         end else begin
            calm = 1'b1;
            mixed_run(20);
            calm = 1'b0;
         end
         idle_request();
      end

      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d queue ops: %0d revoked, %0d evicted, %0d error beats",
               sb.ops_applied, sb.kind_seen[KIND_REVOKED], sb.kind_seen[KIND_EVICTED],
               sb.kind_seen[KIND_ERROR]);
      $display("%0d resident limit settings; largest tick revoked %0d pages",
               limits_applied, sb.widest_tick);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
